@@ rtl/ldm_pkg.sv @@
package ldm_pkg;

	localparam int IMAGE_WIDTH_DEF  = 640;
	localparam int IMAGE_HEIGHT_DEF = 480;
	localparam logic signed [31:0] RADIAL_K3_DEF = 32'sd255970957;

	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int MAPX_W  = 20;
	localparam int MAPY_W  = 19;
	localparam int FOCAL_W = 24;
	localparam int CENTER_W = 23;
	localparam int COEF_W  = 32;
	localparam int CFG_IDX_W = 3;

	// Q.30 intermediates saturated to [-2^31, 2^31] need 33 bits
	localparam int Q_W = 33;
	localparam logic signed [Q_W-1:0] Q_ONE = 33'sd1073741824;
	localparam logic signed [Q_W-1:0] Q_LIM = 33'sd2147483648;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_K1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_K2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_P1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_P2 = 3'd7;

	localparam int DIV_W = 64;

	typedef logic signed [Q_W-1:0] q_t;

	function automatic q_t sat_q(input logic signed [71:0] v);
		if (v > 72'(Q_LIM)) return Q_LIM;
		if (v < -72'(Q_LIM)) return -Q_LIM;
		return v[Q_W-1:0];
	endfunction

	// round half away from zero, shift by 30
	function automatic logic signed [71:0] rnd30(input logic signed [71:0] p);
		logic [71:0] m;
		m = p[71] ? 72'(-p) : 72'(p);
		m = (m + 72'(1 << 29)) >> 30;
		return p[71] ? -$signed(m) : $signed(m);
	endfunction

	function automatic q_t qmul(input q_t a, input q_t b);
		logic signed [71:0] p;
		p = 72'(a) * 72'(b);
		return sat_q(rnd30(p));
	endfunction

endpackage

@@ rtl/ldm_stream_if.sv @@
interface ldm_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ldm_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
module ldm_divider #(
	parameter int NW = 54,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          neg,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic          out_neg
);
	logic [NW-1:0] q_s [NW+1];
	logic [DW:0]   r_s [NW+1];
	logic [DW-1:0] d_s [NW+1];
	logic          n_s [NW+1];
	logic          v_s [NW+1];

	assign q_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;
	assign n_s[0] = neg;
	assign v_s[0] = in_valid;

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW+1:0] trial;
		logic [DW:0]   sh;
		assign sh = {r_s[i][DW-1:0], q_s[i][NW-1]};
		assign trial = {1'b0, sh} - {2'b0, d_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= {q_s[i][NW-2:0], ~trial[DW+1]};
				r_s[i+1] <= trial[DW+1] ? sh : trial[DW:0];
				d_s[i+1] <= d_s[i];
				n_s[i+1] <= n_s[i];
			end
		end
	end

	assign out_valid = v_s[NW];
	assign quo       = q_s[NW];
	assign out_neg   = n_s[NW];
endmodule

@@ rtl/lens_distortion_map_unit.sv @@
// Lens distortion map unit: Brown-Conrady radial and tangential model.
//
// Channels: pixel_in carries one output pixel (pixel_col, pixel_row) per word;
// map_out returns one word per pixel (map_x in Q10.10, map_y in Q9.10, in_frame).
// Configuration: cfg channel takes a register index and 32-bit data; write
// only while the pipe is empty. Index order: focal_x, focal_y, center_x,
// center_y, radial_k1, radial_k2, tangential_p1, tangential_p2.
//
// Throughput: one word per clock while the receiver is ready. The result word
// passes through 54 stages of the pipelined normalising divider (one quotient
// bit each), 8 arithmetic stages and the output register.
// Stage 5 is the widest, with six 33x33 products; the others hold at most three.
//
// Reset clears all valid bits and loads the default calibration.
// When the receiver stalls the whole pipe freezes (shared enable) and an
// output register holds the result word; nothing is lost or repeated.
module lens_distortion_map_unit #(
	parameter int IMAGE_WIDTH  = ldm_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = ldm_pkg::IMAGE_HEIGHT_DEF,
	parameter logic signed [31:0] RADIAL_K3 = ldm_pkg::RADIAL_K3_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ldm_stream_if.sink   pixel_in,
	ldm_stream_if.source map_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ldm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int NW = 54;
	typedef logic signed [ldm_pkg::Q_W-1:0] q_t;

	// configuration registers
	logic [23:0] focal_x_q, focal_y_q;
	logic [22:0] center_x_q, center_y_q;
	logic signed [31:0] k1_q, k2_q, p1_q, p2_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= 24'd548778;
			focal_y_q <= 24'd548778;
			center_x_q <= 23'd350498;
			center_y_q <= 23'd241225;
			k1_q <= -32'sd286015411;
			k2_q <= -32'sd41434516;
			p1_q <= 32'sd1914691;
			p2_q <= -32'sd301959;
		end else if (cfg_valid) begin
			case (cfg_index)
				ldm_pkg::REG_FOCAL_X: focal_x_q <= cfg_data[23:0];
				ldm_pkg::REG_FOCAL_Y: focal_y_q <= cfg_data[23:0];
				ldm_pkg::REG_CENTER_X: center_x_q <= cfg_data[22:0];
				ldm_pkg::REG_CENTER_Y: center_y_q <= cfg_data[22:0];
				ldm_pkg::REG_K1: k1_q <= cfg_data;
				ldm_pkg::REG_K2: k2_q <= cfg_data;
				ldm_pkg::REG_P1: p1_q <= cfg_data;
				ldm_pkg::REG_P2: p2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe advances when the output register is free
	logic en, out_v_q;
	assign en = !out_v_q || map_out.ready;
	assign pixel_in.ready = en;

	// stage 1: centred numerators, magnitude and sign
	logic [9:0] col_in;
	logic [8:0] row_in;
	assign col_in = pixel_in.data[9:0];
	assign row_in = pixel_in.data[18:10];
	logic signed [24:0] nx, ny;
	assign nx = $signed({5'b0, col_in, 10'b0}) - $signed({2'b0, center_x_q});
	assign ny = $signed({6'b0, row_in, 10'b0}) - $signed({2'b0, center_y_q});
	logic [23:0] fxe, fye;
	assign fxe = (focal_x_q == '0) ? 24'd1 : focal_x_q;
	assign fye = (focal_y_q == '0) ? 24'd1 : focal_y_q;
	logic [24:0] ax, ay;
	assign ax = nx[24] ? 25'(-nx) : 25'(nx);
	assign ay = ny[24] ? 25'(-ny) : 25'(ny);

	logic dvx, dvy, xneg, yneg;
	logic [NW-1:0] qx, qy;
	ldm_divider #(.NW(NW), .DW(24)) u_divx (
		.clk, .arst_n, .en, .in_valid(pixel_in.valid && en),
		.num({4'b0, ax, 25'b0} << 5), .den(fxe), .neg(nx[24]),
		.out_valid(dvx), .quo(qx), .out_neg(xneg));
	ldm_divider #(.NW(NW), .DW(24)) u_divy (
		.clk, .arst_n, .en, .in_valid(pixel_in.valid && en),
		.num({4'b0, ay, 25'b0} << 5), .den(fye), .neg(ny[24]),
		.out_valid(dvy), .quo(qy), .out_neg(yneg));

	function automatic q_t sat_mag(input logic [NW-1:0] m, input logic ng);
		logic [NW-1:0] c;
		c = (m > NW'(64'd2147483648)) ? NW'(64'd2147483648) : m;
		return ng ? -q_t'(c) : q_t'(c);
	endfunction

	// s2: normalised coordinates
	logic v_s2; q_t xn_s2, yn_s2;
	// s3: squares and cross term
	logic v_s3; q_t xn_s3, yn_s3, x2_s3, y2_s3, xy_s3;
	// s4: r2 and derived sums
	logic v_s4; q_t xn_s4, yn_s4, r2_s4, xy_s4, tx2_s4, ty2_s4;
	// s5: r4, k1 r2, tangential products
	logic v_s5; q_t xn_s5, yn_s5, r2_s5, r4_s5, a1_s5, tx_s5, ty_s5;
	// s6: r6, k2 r4
	logic v_s6; q_t xn_s6, yn_s6, r6_s6, tx_s6, ty_s6;
	logic signed [35:0] a12_s6;
	// s7: radial factor
	logic v_s7; q_t xn_s7, yn_s7, rad_s7, tx_s7, ty_s7;
	// s8: distorted coordinates
	logic v_s8; q_t xd_s8, yd_s8;
	// s9: pixel units
	logic v_s9; logic signed [47:0] mx_s9, my_s9;

	function automatic logic signed [71:0] sx(input q_t a);
		return 72'(a);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else if (en) begin
			v_s2 <= dvx & dvy; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
		end
	end

	logic signed [71:0] px, py;
	assign px = $signed({48'b0, fxe}) * sx(xd_s8);
	assign py = $signed({48'b0, fye}) * sx(yd_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			xn_s2 <= sat_mag(qx, xneg);
			yn_s2 <= sat_mag(qy, yneg);

			xn_s3 <= xn_s2; yn_s3 <= yn_s2;
			x2_s3 <= ldm_pkg::qmul(xn_s2, xn_s2);
			y2_s3 <= ldm_pkg::qmul(yn_s2, yn_s2);
			xy_s3 <= ldm_pkg::qmul(xn_s2, yn_s2);

			xn_s4 <= xn_s3; yn_s4 <= yn_s3; xy_s4 <= xy_s3;
			r2_s4 <= ldm_pkg::sat_q(sx(x2_s3) + sx(y2_s3));
			tx2_s4 <= ldm_pkg::sat_q(sx(x2_s3) + sx(y2_s3) + 2 * sx(x2_s3));
			ty2_s4 <= ldm_pkg::sat_q(sx(x2_s3) + sx(y2_s3) + 2 * sx(y2_s3));

			xn_s5 <= xn_s4; yn_s5 <= yn_s4; r2_s5 <= r2_s4;
			r4_s5 <= ldm_pkg::qmul(r2_s4, r2_s4);
			a1_s5 <= ldm_pkg::qmul(q_t'(k1_q), r2_s4);
			tx_s5 <= ldm_pkg::sat_q(2 * sx(ldm_pkg::qmul(q_t'(p1_q), xy_s4))
				+ sx(ldm_pkg::qmul(q_t'(p2_q), tx2_s4)));
			ty_s5 <= ldm_pkg::sat_q(sx(ldm_pkg::qmul(q_t'(p1_q), ty2_s4))
				+ 2 * sx(ldm_pkg::qmul(q_t'(p2_q), xy_s4)));

			xn_s6 <= xn_s5; yn_s6 <= yn_s5; tx_s6 <= tx_s5; ty_s6 <= ty_s5;
			r6_s6 <= ldm_pkg::qmul(r4_s5, r2_s5);
			// hold 1 + k1 r2 + k2 r4 unclamped; the one clamp follows the k3 term
			a12_s6 <= 36'(sx(a1_s5)
				+ sx(ldm_pkg::qmul(q_t'(k2_q), r4_s5)) + sx(ldm_pkg::Q_ONE));

			xn_s7 <= xn_s6; yn_s7 <= yn_s6; tx_s7 <= tx_s6; ty_s7 <= ty_s6;
			rad_s7 <= ldm_pkg::sat_q(72'(a12_s6)
				+ sx(ldm_pkg::qmul(q_t'(RADIAL_K3), r6_s6)));

			xd_s8 <= ldm_pkg::sat_q(sx(ldm_pkg::qmul(xn_s7, rad_s7)) + sx(tx_s7));
			yd_s8 <= ldm_pkg::sat_q(sx(ldm_pkg::qmul(yn_s7, rad_s7)) + sx(ty_s7));

			mx_s9 <= 48'(ldm_pkg::rnd30(px)) + 48'(center_x_q);
			my_s9 <= 48'(ldm_pkg::rnd30(py)) + 48'(center_y_q);
		end
	end

	// output register
	logic map_in_frame;
	assign map_in_frame = !mx_s9[47] && !my_s9[47]
		&& mx_s9 <= 48'(IMAGE_WIDTH) * 48'sd1024
		&& my_s9 <= 48'(IMAGE_HEIGHT) * 48'sd1024;
	logic [39:0] out_d_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s9;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_d_q <= map_in_frame ? {1'b1, my_s9[18:0], mx_s9[19:0]} : '0;
		end
	end
	assign map_out.valid = out_v_q;
	assign map_out.data  = out_d_q;
endmodule
